// ===== hdl/tslg_pkg.sv =====
`timescale 1ns / 1ps

package tslg_pkg;

  localparam int CHANNELS     = 2;
  localparam int PHASE_BITS   = 32;
  localparam int SINE_ENTRIES = 1024;
  localparam int SAMPLE_BITS  = 16;

  localparam int CH_BITS     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IDX_BITS    = $clog2(SINE_ENTRIES);
  localparam int QTR_ENTRIES = SINE_ENTRIES / 4;
  localparam int QTR_BITS    = IDX_BITS - 2;
  localparam int SINE_BITS   = 16;

  localparam int TDATA_BITS  = 8 * ((SAMPLE_BITS + 7) / 8);

  localparam int STEP_BITS   = 32;
  localparam int DEPTH_BITS  = 17;
  localparam int CFG_BITS    = 32;
  localparam int CFG_IDX_BITS = 1;
  localparam logic [DEPTH_BITS-1:0] DEPTH_FULL = 17'd65536;

  localparam logic [CFG_IDX_BITS-1:0] REG_PHASE_STEP = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEPTH      = 1'd1;

  // gain m * 2^32, in [0, 2^32]
  localparam int GAIN_BITS = 33;
  localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;

  typedef struct packed {
    logic                  en;
    logic [CH_BITS-1:0]    ch;
    logic [PHASE_BITS-1:0] phase;
  } phase_wr_t;

  typedef logic signed [SINE_BITS-1:0] qtab_t [QTR_ENTRIES];

  // first-quadrant sine, q in [0, QTR_ENTRIES], Taylor series in Q2.30
  function automatic logic signed [SINE_BITS-1:0] sine_quarter(int unsigned q);
    longint unsigned u;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned pos_sum;
    longint unsigned neg_sum;
    longint unsigned s;
    u = 64'(q) << (32 - IDX_BITS);
    x = (u * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    term = x;
    pos_sum = x;
    neg_sum = 64'd0;
    for (int n = 1; n <= 6; n++) begin
      term = (term * x2) >> 30;
      case (n)
        1:       term = term / 6;
        2:       term = term / 20;
        3:       term = term / 42;
        4:       term = term / 72;
        5:       term = term / 110;
        default: term = term / 156;
      endcase
      if ((n % 2) == 1) begin
        neg_sum = neg_sum + term;
      end else begin
        pos_sum = pos_sum + term;
      end
    end
    s = (pos_sum > neg_sum) ? pos_sum - neg_sum : 64'd0;
    if (s > ONE_Q30) begin
      s = ONE_Q30;
    end
    s = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
    return SINE_BITS'(s);
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int i = 0; i < QTR_ENTRIES; i++) begin
      t[i] = sine_quarter(i);
    end
    return t;
  endfunction

  localparam qtab_t SINE_QTAB = build_qtab();
  localparam logic signed [SINE_BITS-1:0] SINE_PEAK = sine_quarter(QTR_ENTRIES);

endpackage

// ===== hdl/tremolo_sine_lfo_gain.sv =====
`timescale 1ns / 1ps
// stages: 0 phase read, 1 sine lookup, 2 gain, 3 product, then the output register
// throughput: one sample per cycle; phase memory is read in stage 0 and written in stage 1,
//   with a bypass when consecutive samples hit the same channel
// the whole pipeline holds while an output transaction waits on m_axis_tready
// reset: all channel phases read as zero, phase_step and depth clear to zero

module tremolo_sine_lfo_gain (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [tslg_pkg::TDATA_BITS-1:0]     s_axis_tdata,  // sample_in
  input  logic                                s_axis_tuser,  // channel
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [tslg_pkg::TDATA_BITS-1:0]     m_axis_tdata,  // sample_out
  input  logic                                cfg_we_i,
  input  logic [tslg_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [tslg_pkg::CFG_BITS-1:0]       cfg_data_i
);

  localparam int SB = tslg_pkg::SAMPLE_BITS;
  localparam int PB = tslg_pkg::PHASE_BITS;
  localparam int IB = tslg_pkg::IDX_BITS;

  logic [tslg_pkg::STEP_BITS-1:0]  phase_step_q;
  logic [tslg_pkg::DEPTH_BITS-1:0] depth_q;
  logic [tslg_pkg::DEPTH_BITS-1:0] depth_wr;

  logic pipe_en;
  logic v1_q, v2_q, v3_q, out_vld_q;

  logic [tslg_pkg::CH_BITS-1:0] ch_in;
  logic [tslg_pkg::CH_BITS-1:0] ch1_q;
  logic signed [SB-1:0] smp1_q, smp2_q, smp3_q;
  logic [SB-1:0]        out_q;

  logic [PB-1:0]             phase1;
  tslg_pkg::phase_wr_t       phase_wr;

  logic [IB-1:0]             tab_idx;
  logic [IB-2:0]             half_idx;
  logic [IB-2:0]             quarter_idx;
  logic signed [tslg_pkg::SINE_BITS-1:0] sine_mag;
  logic signed [tslg_pkg::SINE_BITS-1:0] sine1;
  logic signed [tslg_pkg::SINE_BITS-1:0] sine2_q;

  logic signed [17:0]        sine_off;
  logic signed [17:0]        depth_s;
  logic signed [35:0]        gain_full;
  logic [tslg_pkg::GAIN_BITS-1:0] gain3_q;

  logic signed [tslg_pkg::PROD_BITS-1:0] prod;
  logic signed [tslg_pkg::PROD_BITS-1:0] prod_rnd;

  // configuration registers
  assign depth_wr = cfg_data_i[tslg_pkg::DEPTH_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= '0;
      depth_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tslg_pkg::REG_PHASE_STEP: phase_step_q <= cfg_data_i[tslg_pkg::STEP_BITS-1:0];
        tslg_pkg::REG_DEPTH: begin
          depth_q <= (depth_wr > tslg_pkg::DEPTH_FULL) ? tslg_pkg::DEPTH_FULL : depth_wr;
        end
        default: ;
      endcase
    end
  end

  // pipeline control
  assign pipe_en       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = pipe_en;
  assign ch_in         = (tslg_pkg::CHANNELS > 1) ? tslg_pkg::CH_BITS'(s_axis_tuser) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (pipe_en) begin
      v1_q      <= s_axis_tvalid;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      out_vld_q <= v3_q;
    end
  end

  // stage 0: phase read
  tslg_phase_store u_phase_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (pipe_en && s_axis_tvalid),
    .rd_ch_i (ch_in),
    .wr_i    (phase_wr),
    .phase_o (phase1)
  );

  // stage 1: phase advance and sine lookup
  always_comb begin
    phase_wr.en    = pipe_en && v1_q;
    phase_wr.ch    = ch1_q;
    phase_wr.phase = phase1 + phase_step_q[PB-1:0];
  end

  assign tab_idx  = phase1[PB-1 -: IB];
  assign half_idx = tab_idx[IB-2:0];

  always_comb begin
    if (half_idx > (IB-1)'(tslg_pkg::QTR_ENTRIES)) begin
      quarter_idx = (IB-1)'(tslg_pkg::SINE_ENTRIES / 2) - half_idx;
    end else begin
      quarter_idx = half_idx;
    end
    if (quarter_idx == (IB-1)'(tslg_pkg::QTR_ENTRIES)) begin
      sine_mag = tslg_pkg::SINE_PEAK;
    end else begin
      sine_mag = tslg_pkg::SINE_QTAB[quarter_idx[tslg_pkg::QTR_BITS-1:0]];
    end
    sine1 = tab_idx[IB-1] ? -sine_mag : sine_mag;
  end

  // stage 2: gain = 2^32 + depth * (sine - 2^15)
  assign sine_off  = 18'(sine2_q) - 18'sd32768;
  assign depth_s   = $signed({1'b0, depth_q});
  assign gain_full = (36'sd1 <<< 32) + 36'(depth_s) * 36'(sine_off);

  // stage 3: product, round half up
  assign prod     = tslg_pkg::PROD_BITS'(smp3_q)
                  * tslg_pkg::PROD_BITS'($signed({1'b0, gain3_q}));
  assign prod_rnd = prod + (tslg_pkg::PROD_BITS'(1) <<< 31);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      smp1_q  <= $signed(s_axis_tdata[SB-1:0]);
      ch1_q   <= ch_in;
      smp2_q  <= smp1_q;
      sine2_q <= sine1;
      smp3_q  <= smp2_q;
      gain3_q <= gain_full[tslg_pkg::GAIN_BITS-1:0];
      out_q   <= prod_rnd[32 +: SB];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = tslg_pkg::TDATA_BITS'(out_q);

  a_accept_enters_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v1_q)
    else $error("accepted transaction lost at stage 1");

  a_stage3_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && pipe_en |=> m_axis_tvalid)
    else $error("result lost between last stage and output");

  a_depth_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= tslg_pkg::DEPTH_FULL)
    else $error("depth above full scale");

endmodule

// ===== hdl/tslg_phase_store.sv =====
`timescale 1ns / 1ps

module tslg_phase_store (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           rd_en_i,
  input  logic [tslg_pkg::CH_BITS-1:0]   rd_ch_i,
  input  tslg_pkg::phase_wr_t            wr_i,
  output logic [tslg_pkg::PHASE_BITS-1:0] phase_o
);

  logic [tslg_pkg::PHASE_BITS-1:0] mem_q [tslg_pkg::CHANNELS];
  logic [tslg_pkg::CHANNELS-1:0]   vld_q;
  logic [tslg_pkg::PHASE_BITS-1:0] rdata_q;
  logic [tslg_pkg::PHASE_BITS-1:0] fwd_phase_q;
  logic                            rd_vld_q;
  logic                            fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.ch] <= wr_i.phase;
    end
    if (rd_en_i) begin
      rdata_q     <= mem_q[rd_ch_i];
      fwd_phase_q <= wr_i.phase;
    end
  end

  // entries not yet written read as zero; same-entry write bypasses the array
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.ch] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_ch_i];
        fwd_q    <= wr_i.en && (wr_i.ch == rd_ch_i);
      end
    end
  end

  assign phase_o = fwd_q    ? fwd_phase_q :
                   rd_vld_q ? rdata_q     : '0;

  a_fwd_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i && wr_i.en && (wr_i.ch == rd_ch_i) |=> phase_o == $past(wr_i.phase))
    else $error("phase write not forwarded to colliding read");

  a_unwritten_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i && !vld_q[rd_ch_i] && !(wr_i.en && (wr_i.ch == rd_ch_i)) |=> phase_o == '0)
    else $error("unwritten phase entry did not read as zero");

  a_write_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.en |=> vld_q[$past(wr_i.ch)])
    else $error("written phase entry not marked valid");

endmodule

// ===== tb/tb_tremolo_sine_lfo_gain.sv =====
`timescale 1ns / 1ps

module tb_tremolo_sine_lfo_gain;

  localparam int LUT_SIZE = 1024;
  localparam int LUT_BITS = 10;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RAND_PHASES = 9;
  localparam int PHASE_ITEMS = 150;
  localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
  localparam longint unsigned Q30_ONE = 64'd1073741824;

  logic                                clk_i = 1'b0;
  logic                                rst_ni;
  logic                                s_axis_tvalid;
  logic                                s_axis_tready;
  logic [tslg_pkg::TDATA_BITS-1:0]     s_axis_tdata;
  logic                                s_axis_tuser;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready;
  logic [tslg_pkg::TDATA_BITS-1:0]     m_axis_tdata;
  logic                                cfg_we_i;
  logic [tslg_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i;
  logic [tslg_pkg::CFG_BITS-1:0]       cfg_data_i;

  tremolo_sine_lfo_gain u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // sample_in
    .s_axis_tuser  (s_axis_tuser),   // channel
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // sample_out
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // predictor state
  int          sine_lut [LUT_SIZE];
  logic [31:0] lfo_phase [2];
  logic [31:0] step_reg;
  longint      depth_reg;

  logic [15:0] modulated_q [$];
  int          errors;
  int          samples_sent;
  int          settings_used;
  int          checked;
  int          sink_wait;
  bit          out_taken;
  int          idle_cycles;
  bit          no_idle;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int sine_code(int unsigned k);
    longint unsigned u;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned pos_sum;
    longint unsigned neg_sum;
    longint unsigned s;
    bit              neg;
    u = (64'(k) << 32) / LUT_SIZE;
    neg = 1'b0;
    if (u >= 64'h8000_0000) begin
      neg = 1'b1;
      u = u - 64'h8000_0000;
    end
    if (u > 64'h4000_0000) begin
      u = 64'h8000_0000 - u;
    end
    x = (u * Q30_HALF_PI) >> 30;
    x2 = (x * x) >> 30;
    term = x;
    pos_sum = x;
    neg_sum = 0;
    for (int n = 1; n <= 6; n++) begin
      term = (term * x2) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        neg_sum = neg_sum + term;
      end else begin
        pos_sum = pos_sum + term;
      end
    end
    s = (pos_sum > neg_sum) ? pos_sum - neg_sum : 64'd0;
    if (s > Q30_ONE) begin
      s = Q30_ONE;
    end
    s = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
    return neg ? -int'(s) : int'(s);
  endfunction

  // gain = 2^32 - depth*2^15 + depth*sine, output rounded ties up
  function automatic logic [15:0] modulate_sample(logic signed [15:0] smp, bit ch);
    logic [31:0] ph;
    longint      sv;
    longint      gain;
    longint      prod;
    longint      y;
    ph = lfo_phase[ch];
    sv = sine_lut[ph[31 -: LUT_BITS]];
    gain = 64'sd4294967296 - depth_reg * 32768 + depth_reg * sv;
    prod = longint'(smp) * gain;
    y = (prod + 64'sd2147483648) >>> 32;
    lfo_phase[ch] = ph + step_reg;
    return y[15:0];
  endfunction

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic logic [15:0] draw_sample();
    case ($urandom_range(0, 11))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %0s at %0t: got %0d expected %0d", what, $time,
             $signed(got), $signed(want));
    errors++;
  endtask

  // leaves tvalid high at a falling edge so the next item can follow directly
  task automatic send_sample(logic [15:0] smp, bit ch);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= smp;
    s_axis_tuser <= ch;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    modulated_q.push_back(modulate_sample(smp, ch));
    samples_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (modulated_q.size() > 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [tslg_pkg::CFG_IDX_BITS-1:0] idx, logic [31:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == tslg_pkg::REG_PHASE_STEP) begin
      step_reg = value;
    end else begin
      depth_reg = (value[16:0] > 17'd65536) ? 65536 : longint'(value[16:0]);
    end
    @(negedge clk_i);
  endtask

  task automatic set_lfo(logic [31:0] step, logic [31:0] dep);
    write_reg(tslg_pkg::REG_PHASE_STEP, step);
    write_reg(tslg_pkg::REG_DEPTH, dep);
    settings_used++;
  endtask

  task automatic test_passthrough();
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0001, 1'b0);
    drain();
  endtask

  // quarter turn steps land on zero, peak, zero and trough of the sine
  task automatic test_full_depth();
    set_lfo(32'h4000_0000, 32'h0001_0000);
    for (int i = 0; i < 8; i++) begin
      send_sample((i % 2 == 0) ? 16'h7FFF : 16'h8000, i[2]);
    end
    drain();
  endtask

  task automatic test_depth_saturation();
    set_lfo(32'h8000_0000, 32'hFFFF_FFFF);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h8000, 1'b1);
    drain();
    set_lfo(32'h0000_0001, 32'h0001_0001);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    drain();
  endtask

  task automatic test_phase_wrap();
    set_lfo(32'hFFFF_FFFF, 32'h0000_8000);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h8000, 1'b1);
    drain();
  endtask

  task automatic test_random();
    logic [31:0] step;
    logic [31:0] dep;
    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(0, 5))
        0:       step = 32'h0000_0000;
        1:       step = 32'h8000_0000;
        2:       step = 32'hFFFF_FFFF;
        3:       step = $urandom_range(0, 32'h00FF_FFFF);
        default: step = $urandom;
      endcase
      case ($urandom_range(0, 5))
        0:       dep = $urandom & 32'hFFFE_0000;
        1:       dep = ($urandom & 32'hFFFE_0000) | 32'h0001_0000;
        2:       dep = $urandom | 32'h0001_FFFF;
        3:       dep = $urandom;
        default: dep = $urandom & 32'hFFFE_FFFF;
      endcase
      set_lfo(step, dep);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 39) == 0) begin
          no_idle = !no_idle;
        end
        send_sample(draw_sample(), 1'($urandom_range(0, 1)));
      end
      drain();
    end
    no_idle = 1'b0;
  endtask

  // output side: random backpressure
  always @(negedge clk_i) begin
    if (out_taken) begin
      sink_wait = draw_wait();
    end
    if (sink_wait > 0) begin
      m_axis_tready <= 1'b0;
      sink_wait--;
    end else begin
      m_axis_tready <= rst_ni;
    end
  end

  always @(posedge clk_i) begin
    out_taken = rst_ni && m_axis_tvalid && m_axis_tready;
    if (out_taken) begin
      if (modulated_q.size() == 0) begin
        report("unexpected output", m_axis_tdata, 16'h0000);
      end else begin
        if (m_axis_tdata !== modulated_q[0]) begin
          report("sample_out", m_axis_tdata, modulated_q[0]);
        end
        void'(modulated_q.pop_front());
      end
      checked++;
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("no progress for %0d cycles", STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    errors = 0;
    samples_sent = 0;
    settings_used = 1;
    checked = 0;
    no_idle = 1'b0;
    for (int k = 0; k < LUT_SIZE; k++) begin
      sine_lut[k] = sine_code(k);
    end
    lfo_phase[0] = '0;
    lfo_phase[1] = '0;
    step_reg = '0;
    depth_reg = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_passthrough();
    test_full_depth();
    test_depth_saturation();
    test_phase_wrap();
    test_random();

    $display("checked %0d of %0d samples on both channels under %0d lfo settings",
             checked, samples_sent, settings_used);
    $display("settings included zero and full depth, saturated depth and phase wrap");
    if (errors == 0 && modulated_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d outputs missing", errors, modulated_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
